[hw/rtl/h2fc_pkg.sv]
// Shared types and constants for the HTTP/2 receive parser with send flow control.
`default_nettype none

package h2fc_pkg;

  // Result kinds carried on the master-side tuser
  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_SET_ACK  = 3'd1;
  localparam logic [2:0] KIND_PING_ACK = 3'd2;
  localparam logic [2:0] KIND_FAIL     = 3'd3;
  localparam logic [2:0] KIND_GRANT    = 3'd4;

  // Request kinds carried on the slave-side tuser
  localparam logic REQ_RX_BYTE = 1'b0;
  localparam logic REQ_SEND    = 1'b1;

  // Frame types
  localparam logic [7:0] FT_DATA     = 8'h00;
  localparam logic [7:0] FT_RST      = 8'h03;
  localparam logic [7:0] FT_SETTINGS = 8'h04;
  localparam logic [7:0] FT_PING     = 8'h06;
  localparam logic [7:0] FT_GOAWAY   = 8'h07;
  localparam logic [7:0] FT_WUPD     = 8'h08;

  localparam int unsigned FLAG_ACK_BIT = 0;
  localparam logic [15:0] SET_INIT_WIN = 16'h0004;

  localparam logic [30:0] WIN_DEFAULT = 31'd65535;
  localparam logic [30:0] WIN_MAX     = 31'h7FFF_FFFF;
  localparam logic [23:0] LIMIT_RESET = 24'd16384;

  // Header is 9 bytes; positions 0..8
  localparam logic [24:0] HDR_LEN = 25'd9;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [30:0] data_stream;
    logic        data_last;
    logic [23:0] grant_count;
    logic        settings_known;
    logic        link_failed;
  } result_t;

  // Add a 31-bit increment to a window, saturating at the window maximum
  function automatic logic [30:0] win_sat_add(input logic [30:0] w, input logic [30:0] inc);
    logic [31:0] s;
    s = {1'b0, w} + {1'b0, inc};
    win_sat_add = s[31] ? WIN_MAX : s[30:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/h2fc_core.sv]
// Frame parser state, window bookkeeping and result formation for one item.
`default_nettype none

module h2fc_core
  import h2fc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_en,
  input  wire logic        req_type,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [31:0] send_remaining,
  input  wire logic        cfg_wen,
  input  wire logic [23:0] cfg_wdata,
  output logic             res_valid,
  output result_t          res
);

  logic [24:0] frame_pos, frame_pos_next;
  logic [23:0] frame_len, frame_len_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  frame_flags, frame_flags_next;
  logic [30:0] frame_stream, frame_stream_next;
  logic [15:0] entry_id, entry_id_next;
  logic [31:0] entry_value, entry_value_next;
  logic [2:0]  entry_pos, entry_pos_next;
  logic [30:0] conn_window, conn_window_next;
  logic [30:0] strm_window, strm_window_next;
  logic        seen_settings, seen_settings_next;
  logic        fail_flag, fail_flag_next;
  logic [23:0] send_frame_limit;

  logic [24:0] pay_cnt;
  logic        pay_last;
  logic        frame_end;
  logic        is_ack;
  logic [30:0] min_win;
  logic [23:0] budget;
  logic [23:0] grant;

  assign pay_cnt = frame_pos - 25'd8;
  assign pay_last = (pay_cnt >= {1'b0, frame_len});

  // Send budget: least of both windows, the frame limit and the bytes remaining
  assign min_win = (conn_window < strm_window) ? conn_window : strm_window;
  assign budget  = ({7'd0, send_frame_limit} < min_win) ? send_frame_limit : min_win[23:0];
  assign grant   = (send_remaining < {8'd0, budget}) ? send_remaining[23:0] : budget;

  // Next state and result for the presented item
  always_comb begin
    frame_pos_next     = frame_pos;
    frame_len_next     = frame_len;
    frame_type_next    = frame_type;
    frame_flags_next   = frame_flags;
    frame_stream_next  = frame_stream;
    entry_id_next      = entry_id;
    entry_value_next   = entry_value;
    entry_pos_next     = entry_pos;
    conn_window_next   = conn_window;
    strm_window_next   = strm_window;
    seen_settings_next = seen_settings;
    fail_flag_next     = fail_flag;
    frame_end          = 1'b0;
    is_ack             = 1'b0;
    res_valid          = 1'b0;
    res                = '0;

    if (req_type == REQ_RX_BYTE) begin
      if (frame_pos < HDR_LEN) begin
        // Collect the header fields
        unique case (frame_pos[3:0])
          4'd0: frame_len_next = {rx_byte, 16'd0};
          4'd1: frame_len_next = {frame_len[23:16], rx_byte, frame_len[7:0]};
          4'd2: frame_len_next = {frame_len[23:8], rx_byte};
          4'd3: frame_type_next = rx_byte;
          4'd4: frame_flags_next = rx_byte;
          4'd5: frame_stream_next = {rx_byte[6:0], 24'd0};
          4'd6: frame_stream_next = {frame_stream[30:24], rx_byte, frame_stream[15:0]};
          4'd7: frame_stream_next = {frame_stream[30:16], rx_byte, frame_stream[7:0]};
          default: frame_stream_next = {frame_stream[30:8], rx_byte};
        endcase
        frame_pos_next = frame_pos + 25'd1;
        if (frame_pos[3:0] == 4'd8) begin
          entry_pos_next   = 3'd0;
          entry_id_next    = 16'd0;
          entry_value_next = 32'd0;
          if (frame_len == 24'd0) begin
            frame_pos_next = 25'd0;
            frame_end      = 1'b1;
          end
        end
      end else begin
        // Payload byte
        if (frame_type == FT_DATA) begin
          res_valid        = 1'b1;
          res.kind         = KIND_DATA;
          res.data_byte    = rx_byte;
          res.data_stream  = frame_stream;
          res.data_last    = pay_last;
        end else if (frame_type == FT_WUPD) begin
          if (frame_pos < 25'd13) begin
            entry_value_next = {entry_value[23:0], rx_byte};
          end
        end else if (frame_type == FT_SETTINGS && !frame_flags[FLAG_ACK_BIT]) begin
          if (entry_pos < 3'd2) begin
            entry_id_next = {entry_id[7:0], rx_byte};
          end else begin
            entry_value_next = {entry_value[23:0], rx_byte};
          end
          if (entry_pos >= 3'd5) begin
            if (entry_id_next == SET_INIT_WIN) begin
              strm_window_next = entry_value_next[31] ? WIN_MAX : entry_value_next[30:0];
            end
            entry_pos_next   = 3'd0;
            entry_id_next    = 16'd0;
            entry_value_next = 32'd0;
          end else begin
            entry_pos_next = entry_pos + 3'd1;
          end
        end
        if (pay_last) begin
          frame_pos_next = 25'd0;
          frame_end      = (frame_type != FT_DATA);
        end else begin
          frame_pos_next = frame_pos + 25'd1;
        end
      end

      // Act on a completed control frame
      if (frame_end) begin
        is_ack = frame_flags_next[FLAG_ACK_BIT];
        priority if (frame_type_next == FT_SETTINGS) begin
          if (!is_ack) begin
            seen_settings_next = 1'b1;
            res_valid          = 1'b1;
            res.kind           = KIND_SET_ACK;
          end
        end else if (frame_type_next == FT_WUPD) begin
          if (frame_len_next >= 24'd4) begin
            if (frame_stream_next == 31'd0) begin
              conn_window_next = win_sat_add(conn_window, entry_value_next[30:0]);
            end else begin
              strm_window_next = win_sat_add(strm_window, entry_value_next[30:0]);
            end
          end
        end else if (frame_type_next == FT_PING) begin
          if (!is_ack) begin
            res_valid = 1'b1;
            res.kind  = KIND_PING_ACK;
          end
        end else if (frame_type_next == FT_GOAWAY || frame_type_next == FT_RST) begin
          fail_flag_next = 1'b1;
          res_valid      = 1'b1;
          res.kind       = KIND_FAIL;
        end else begin
          res_valid = 1'b0;
        end
      end
    end else begin
      // Send request: grant and debit both windows
      conn_window_next = conn_window - {7'd0, grant};
      strm_window_next = strm_window - {7'd0, grant};
      res_valid        = 1'b1;
      res.kind         = KIND_GRANT;
      res.grant_count  = grant;
    end

    res.settings_known = seen_settings_next;
    res.link_failed    = fail_flag_next;
  end

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos     <= '0;
      frame_len     <= '0;
      frame_type    <= '0;
      frame_flags   <= '0;
      frame_stream  <= '0;
      entry_id      <= '0;
      entry_value   <= '0;
      entry_pos     <= '0;
      conn_window   <= WIN_DEFAULT;
      strm_window   <= WIN_DEFAULT;
      seen_settings <= 1'b0;
      fail_flag     <= 1'b0;
    end else if (item_en) begin
      frame_pos     <= frame_pos_next;
      frame_len     <= frame_len_next;
      frame_type    <= frame_type_next;
      frame_flags   <= frame_flags_next;
      frame_stream  <= frame_stream_next;
      entry_id      <= entry_id_next;
      entry_value   <= entry_value_next;
      entry_pos     <= entry_pos_next;
      conn_window   <= conn_window_next;
      strm_window   <= strm_window_next;
      seen_settings <= seen_settings_next;
      fail_flag     <= fail_flag_next;
    end
  end

  // Hold the frame limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      send_frame_limit <= LIMIT_RESET;
    end else if (cfg_wen) begin
      send_frame_limit <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/http2_frame_rx_flow_control.sv]
// Top level: HTTP/2 receive frame parser with send-side flow control.
//
// Usage:
//   Slave stream s_*: one transfer per item. s_tuser selects the request:
//   a received connection byte (s_tdata[7:0]) or a send request carrying
//   the payload bytes still to send (s_tdata[39:8]).
//   Master stream m_*: zero or one result per item. m_tuser gives the kind
//   (data byte, SETTINGS ack, PING ack, peer failure, send grant); m_tlast
//   marks the last payload byte of a DATA frame.
//   cfg_wen/cfg_wdata write the per-request frame limit; write only while
//   no transfer is in flight.
// Results are registered: a result appears on m_* in the cycle after its input transfer.
// Throughput: one item per cycle while the output is not stalled, set by the
//   single registered pass through the parser/window logic into the output register.
// Reset (rst, synchronous): parser at the start of a frame header, both
//   windows 65535, frame limit 16384, flags clear, output empty.
// Stall: while a result waits with m_tready low, s_tready drops and the
//   parser holds; an item that yields no result still needs the output slot
//   free or draining in that cycle.
`default_nettype none

module http2_frame_rx_flow_control
  import h2fc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [7:0] rx_byte, [39:8] send_remaining
  input  wire logic [0:0]  s_tuser,   // [0] req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [7:0] data_byte, [38:8] data_stream,
                                      // [62:39] grant_count, [63] settings_known,
                                      // [64] link_failed, [71:65] zero
  output logic [2:0]       m_tuser,   // [2:0] out_kind
  output logic             m_tlast,   // data_last
  input  wire logic        cfg_wen,
  input  wire logic [23:0] cfg_wdata
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  h2fc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .item_en        (accept),
    .req_type       (s_tuser[0]),
    .rx_byte        (s_tdata[7:0]),
    .send_remaining (s_tdata[39:8]),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .res_valid      (res_valid),
    .res            (res)
  );

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.link_failed, out_res.settings_known, out_res.grant_count,
                    out_res.data_stream, out_res.data_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.data_last;

endmodule

`default_nettype wire

[hw/rtl/h2fc_checker.sv]
// Port-level checker for the HTTP/2 receive parser, bound to the top level.
`default_nettype none

module h2fc_checker
  import h2fc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
      $stable(m_tlast))
    else $error("stalled result changed");

  // Last mark only on DATA payload bytes
  a_last_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == KIND_DATA)
    else $error("tlast on non-data result");

  // Grant count is zero except on grants
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_GRANT |-> m_tdata[62:39] == 24'd0)
    else $error("grant count on non-grant result");

  // A failure report carries the failed flag, a SETTINGS ack the known flag
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_FAIL) |-> m_tdata[64])
    else $error("failure without link_failed");

  a_set_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_SET_ACK) |-> m_tdata[63])
    else $error("settings ack without settings_known");

endmodule

bind http2_frame_rx_flow_control h2fc_checker u_h2fc_checker (.*);

`default_nettype wire
